[sv/gcvs_pkg.sv]
`default_nettype none

package gcvs_pkg;

   localparam int unsigned FUNC_W  = 3;
   localparam int unsigned BLOCK_W = 10;
   localparam int unsigned PAGE_W  = 6;
   localparam int unsigned PLANE_W = 2;
   localparam int unsigned PCNT_W  = 7;
   localparam int unsigned COUNT_W = 17;
   localparam int unsigned ROW_MAX = 64;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [FUNC_W-1:0] FUNC_MARK_USED  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_MARK_DIRTY = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_ERASE      = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_PICK       = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_PICK_PLANE = 3'd4;

   localparam logic CSR_IDLE_THR  = 1'b0;
   localparam logic CSR_FORCE_THR = 1'b1;

   localparam logic [COUNT_W-1:0] IDLE_THR_RESET  = 17'd45875;
   localparam logic [COUNT_W-1:0] FORCE_THR_RESET = 17'd58982;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [BLOCK_W-1:0] block;
      logic [PAGE_W-1:0]  page;
      logic [PLANE_W-1:0] plane;
   } req_type;

   typedef struct packed {
      logic [BLOCK_W-1:0] victim_block;
      logic [PCNT_W-1:0]  victim_dirty_pages;
      logic [PCNT_W-1:0]  live_pages;
      logic [COUNT_W-1:0] used_total;
      logic [COUNT_W-1:0] dirty_total;
      logic               idle_gc_wanted;
      logic               panic_gc_wanted;
      logic               full_no_dirty;
   } rsp_type;

   function automatic logic [PCNT_W-1:0] popcount(input logic [ROW_MAX-1:0] row);
      logic [PCNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < ROW_MAX; i++) begin
         n = n + PCNT_W'(row[i]);
      end
      return n;
   endfunction

   function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
      return (c == COUNT_MAX) ? c : c + 1'b1;
   endfunction

   function automatic logic [COUNT_W-1:0] count_down(input logic [COUNT_W-1:0] c,
                                                     input logic [PCNT_W-1:0]  by);
      return (COUNT_W'(by) > c) ? '0 : c - COUNT_W'(by);
   endfunction

endpackage

`default_nettype wire

[sv/gcvs_map_ram.sv]
`default_nettype none

module gcvs_map_ram #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned WIDTH = 128,
   parameter int unsigned AW    = 10
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[sv/greedy_gc_victim_select.sv]
// Mark and erase: read, modify/write and output steps (ST_RD, ST_MOD, ST_FIN).
// Victim pick: setup, scan, victim read, victim wait and output; one bitmap row read per
// cycle during the scan from the single-port read side of the map memory.
// One item is in flight at a time; the result register frees the input side.
// Reset (synchronous) clears counts and pointer, reloads the default thresholds, then
// sweeps all NUM_BLOCKS rows of the map memory to zero with req_stall high.
`default_nettype none

module greedy_gc_victim_select #(
   parameter int unsigned NUM_BLOCKS      = 1024,
   parameter int unsigned PAGES_IN_BLOCK  = 64,
   parameter int unsigned BLOCKS_IN_PLANE = 256
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire gcvs_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output gcvs_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic                                 csr_index,
   input  wire logic [gcvs_pkg::COUNT_W-1:0]         csr_wdata
);

   localparam int unsigned BW     = $clog2(NUM_BLOCKS);
   localparam int unsigned PTR_W  = $clog2(NUM_BLOCKS + 1);
   localparam int unsigned P      = PAGES_IN_BLOCK;
   localparam int unsigned ROW_W  = 2 * P;
   localparam int unsigned TOTAL  = NUM_BLOCKS * PAGES_IN_BLOCK;
   localparam int unsigned CW     = gcvs_pkg::COUNT_W;
   localparam int unsigned NW     = gcvs_pkg::PCNT_W;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RD, ST_MOD, ST_SETUP, ST_SCAN, ST_VIC_RD, ST_VIC_WAIT, ST_FIN
   } state_type;

   state_type                state_ff, state_in;
   logic [BW-1:0]            clr_ff, clr_in;
   gcvs_pkg::req_type        req_ff, req_in;
   logic [CW-1:0]            used_cnt_ff, used_cnt_in;
   logic [CW-1:0]            dirty_cnt_ff, dirty_cnt_in;
   logic [BW-1:0]            scan_start_ff, scan_start_in;
   logic [CW-1:0]            idle_thr_ff, idle_thr_in;
   logic [CW-1:0]            force_thr_ff, force_thr_in;
   logic [PTR_W-1:0]         issue_ptr_ff, issue_ptr_in;
   logic [PTR_W-1:0]         hi_ff, hi_in;
   logic                     v1_ff, v1_in;
   logic                     v2_ff, v2_in;
   logic [BW-1:0]            a1_ff, a1_in;
   logic [BW-1:0]            a2_ff, a2_in;
   logic [NW-1:0]            cnt_ff, cnt_in;
   logic [BW-1:0]            best_ff, best_in;
   logic [NW-1:0]            best_n_ff, best_n_in;
   logic [gcvs_pkg::BLOCK_W-1:0] vic_block_ff, vic_block_in;
   logic [NW-1:0]            vic_dirty_ff, vic_dirty_in;
   logic [NW-1:0]            vic_live_ff, vic_live_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   gcvs_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                     mem_wr_en;
   logic [BW-1:0]            mem_wr_addr;
   logic [ROW_W-1:0]         mem_wr_data;
   logic [BW-1:0]            mem_rd_addr;
   logic [ROW_W-1:0]         mem_rd_data;

   logic [P-1:0]             used_row;
   logic [P-1:0]             dirty_row;
   logic [P-1:0]             page_bit;
   logic [gcvs_pkg::ROW_MAX-1:0] page_sel;
   logic                     blk_ok;
   logic                     pg_ok;
   logic [BW-1:0]            blk_addr;
   logic [31:0]              lo_w;
   logic [31:0]              hi_sum;
   logic [31:0]              hi_w;
   logic                     issue;

   gcvs_map_ram #(
      .DEPTH (NUM_BLOCKS),
      .WIDTH (ROW_W),
      .AW    (BW)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign used_row  = mem_rd_data[ROW_W-1:P];
   assign dirty_row = mem_rd_data[P-1:0];
   assign page_sel  = gcvs_pkg::ROW_MAX'(1) << req_ff.page;
   assign page_bit  = page_sel[P-1:0];
   assign blk_ok    = 32'(req_ff.block) < NUM_BLOCKS;
   assign pg_ok     = 32'(req_ff.page) < PAGES_IN_BLOCK;
   assign blk_addr  = BW'(req_ff.block);
   assign issue     = issue_ptr_ff < hi_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      req_in        = req_ff;
      used_cnt_in   = used_cnt_ff;
      dirty_cnt_in  = dirty_cnt_ff;
      scan_start_in = scan_start_ff;
      idle_thr_in   = idle_thr_ff;
      force_thr_in  = force_thr_ff;
      issue_ptr_in  = issue_ptr_ff;
      hi_in         = hi_ff;
      v1_in         = v1_ff;
      v2_in         = v2_ff;
      a1_in         = a1_ff;
      a2_in         = a2_ff;
      cnt_in        = cnt_ff;
      best_in       = best_ff;
      best_n_in     = best_n_ff;
      vic_block_in  = vic_block_ff;
      vic_dirty_in  = vic_dirty_ff;
      vic_live_in   = vic_live_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = blk_addr;
      mem_wr_data   = '0;
      mem_rd_addr   = issue_ptr_ff[BW-1:0];
      lo_w          = (req_ff.func == gcvs_pkg::FUNC_PICK)
                      ? 32'(scan_start_ff)
                      : 32'(req_ff.plane) * 32'(BLOCKS_IN_PLANE);
      hi_sum        = lo_w + 32'(BLOCKS_IN_PLANE);
      hi_w          = (req_ff.func == gcvs_pkg::FUNC_PICK || hi_sum > NUM_BLOCKS)
                      ? 32'(NUM_BLOCKS) : hi_sum;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gcvs_pkg::CSR_IDLE_THR:  idle_thr_in  = csr_wdata;
            gcvs_pkg::CSR_FORCE_THR: force_thr_in = csr_wdata;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            if (clr_ff == BW'(NUM_BLOCKS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in       = req_data;
               vic_block_in = '0;
               vic_dirty_in = '0;
               vic_live_in  = '0;
               unique case (req_data.func)
                  gcvs_pkg::FUNC_MARK_USED,
                  gcvs_pkg::FUNC_MARK_DIRTY,
                  gcvs_pkg::FUNC_ERASE:      state_in = ST_RD;
                  gcvs_pkg::FUNC_PICK,
                  gcvs_pkg::FUNC_PICK_PLANE: state_in = ST_SETUP;
                  default:                   state_in = ST_FIN;
               endcase
            end
         end
         ST_RD: begin
            mem_rd_addr = blk_addr;
            state_in    = ST_MOD;
         end
         ST_MOD: begin
            unique case (req_ff.func)
               gcvs_pkg::FUNC_MARK_USED: begin
                  if (blk_ok && pg_ok && (used_row & page_bit) == '0) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = {used_row | page_bit, dirty_row};
                     used_cnt_in = gcvs_pkg::count_up(used_cnt_ff);
                  end
               end
               gcvs_pkg::FUNC_MARK_DIRTY: begin
                  if (blk_ok && pg_ok && (dirty_row & page_bit) == '0) begin
                     mem_wr_en    = 1'b1;
                     mem_wr_data  = {used_row, dirty_row | page_bit};
                     dirty_cnt_in = gcvs_pkg::count_up(dirty_cnt_ff);
                  end
               end
               gcvs_pkg::FUNC_ERASE: begin
                  if (blk_ok) begin
                     mem_wr_en    = 1'b1;
                     mem_wr_data  = '0;
                     used_cnt_in  = gcvs_pkg::count_down(used_cnt_ff,
                                       gcvs_pkg::popcount(gcvs_pkg::ROW_MAX'(used_row)));
                     dirty_cnt_in = gcvs_pkg::count_down(dirty_cnt_ff,
                                       gcvs_pkg::popcount(gcvs_pkg::ROW_MAX'(dirty_row)));
                  end
               end
               default: begin
               end
            endcase
            state_in = ST_FIN;
         end
         ST_SETUP: begin
            if (lo_w < hi_w) begin
               issue_ptr_in = PTR_W'(lo_w);
               hi_in        = PTR_W'(hi_w);
            end else begin
               issue_ptr_in = '0;
               hi_in        = '0;
            end
            v1_in     = 1'b0;
            v2_in     = 1'b0;
            best_in   = '0;
            best_n_in = '0;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            v1_in  = issue;
            a1_in  = issue_ptr_ff[BW-1:0];
            if (issue) begin
               issue_ptr_in = issue_ptr_ff + 1'b1;
            end
            v2_in  = v1_ff;
            a2_in  = a1_ff;
            cnt_in = gcvs_pkg::popcount(gcvs_pkg::ROW_MAX'(dirty_row));
            if (v2_ff && cnt_ff > best_n_ff) begin
               best_in   = a2_ff;
               best_n_in = cnt_ff;
            end
            if (!issue && !v1_ff && !v2_ff) begin
               state_in = ST_VIC_RD;
            end
         end
         ST_VIC_RD: begin
            mem_rd_addr = best_ff;
            state_in    = ST_VIC_WAIT;
         end
         ST_VIC_WAIT: begin
            vic_block_in = gcvs_pkg::BLOCK_W'(best_ff);
            vic_dirty_in = gcvs_pkg::popcount(gcvs_pkg::ROW_MAX'(dirty_row));
            vic_live_in  = gcvs_pkg::popcount(gcvs_pkg::ROW_MAX'(used_row & ~dirty_row));
            if (req_ff.func == gcvs_pkg::FUNC_PICK) begin
               scan_start_in = (best_ff == BW'(NUM_BLOCKS - 1)) ? '0 : best_ff + 1'b1;
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.victim_block       = vic_block_ff;
               rsp_data_in.victim_dirty_pages = vic_dirty_ff;
               rsp_data_in.live_pages         = vic_live_ff;
               rsp_data_in.used_total         = used_cnt_ff;
               rsp_data_in.dirty_total        = dirty_cnt_ff;
               rsp_data_in.idle_gc_wanted     = used_cnt_ff > idle_thr_ff;
               rsp_data_in.panic_gc_wanted    = used_cnt_ff >= force_thr_ff;
               rsp_data_in.full_no_dirty      = (32'(used_cnt_ff) >= TOTAL)
                                                && (dirty_cnt_ff == '0);
               state_in                       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         used_cnt_ff   <= '0;
         dirty_cnt_ff  <= '0;
         scan_start_ff <= '0;
         idle_thr_ff   <= gcvs_pkg::IDLE_THR_RESET;
         force_thr_ff  <= gcvs_pkg::FORCE_THR_RESET;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         used_cnt_ff   <= used_cnt_in;
         dirty_cnt_ff  <= dirty_cnt_in;
         scan_start_ff <= scan_start_in;
         idle_thr_ff   <= idle_thr_in;
         force_thr_ff  <= force_thr_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff       <= req_in;
      issue_ptr_ff <= issue_ptr_in;
      hi_ff        <= hi_in;
      a1_ff        <= a1_in;
      a2_ff        <= a2_in;
      cnt_ff       <= cnt_in;
      best_ff      <= best_in;
      best_n_ff    <= best_n_in;
      vic_block_ff <= vic_block_in;
      vic_dirty_ff <= vic_dirty_in;
      vic_live_ff  <= vic_live_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

`default_nettype wire

[verif/greedy_gc_victim_select_checker.sv]
`timescale 1ns / 100ps

module greedy_gc_victim_select_checker #(
   parameter int unsigned NUM_BLOCKS      = 1024,
   parameter int unsigned PAGES_IN_BLOCK  = 64,
   parameter int unsigned BLOCKS_IN_PLANE = 256
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_stall,
   input  wire gcvs_pkg::req_type            req_data,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   input  wire gcvs_pkg::rsp_type            rsp_data,
   input  wire logic                         csr_valid,
   input  wire logic                         csr_ready,
   input  wire logic                         csr_index,
   input  wire logic [gcvs_pkg::COUNT_W-1:0] csr_wdata,
   output int unsigned                       mismatch_count,
   output int unsigned                       results_owed
);

   localparam int unsigned RW         = gcvs_pkg::ROW_MAX;
   localparam int unsigned CW         = gcvs_pkg::COUNT_W;
   localparam int unsigned OWED_DEPTH = 16;
   localparam logic [RW-1:0] ROW_MASK = (PAGES_IN_BLOCK >= RW) ?
      {RW{1'b1}} : ((64'd1 << PAGES_IN_BLOCK) - 64'd1);

   logic [RW-1:0]     used_rows  [NUM_BLOCKS];
   logic [RW-1:0]     dirty_rows [NUM_BLOCKS];
   logic [CW-1:0]     used_pages;
   logic [CW-1:0]     dirty_pages;
   logic [CW-1:0]     idle_thr;
   logic [CW-1:0]     force_thr;
   int unsigned       scan_ptr;
   gcvs_pkg::rsp_type owed_results [OWED_DEPTH];
   int unsigned       owed_head;
   int unsigned       owed_tail;
   int unsigned       owed_level;

   function automatic int unsigned ones_in(input logic [RW-1:0] row);
      int unsigned n;
      n = 0;
      for (int i = 0; i < RW; i++) begin
         n += row[i];
      end
      return n;
   endfunction

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
      if (c == {CW{1'b1}}) begin
         return c;
      end
      return c + 1'b1;
   endfunction

   function automatic logic [CW-1:0] sat_dec(input logic [CW-1:0] c,
                                             input int unsigned by);
      if (by > c) begin
         return '0;
      end
      return c - CW'(by);
   endfunction

   // Applies one operation to the shadow maps and returns the result it causes.
   function automatic gcvs_pkg::rsp_type predict_gc_op(input gcvs_pkg::req_type op);
      gcvs_pkg::rsp_type res;
      int unsigned       lo, hi, best, best_n, n;
      logic              blk_ok, pg_ok;
      res    = '0;
      blk_ok = op.block < NUM_BLOCKS;
      pg_ok  = op.page < PAGES_IN_BLOCK;
      unique case (op.func)
         gcvs_pkg::FUNC_MARK_USED: begin
            if (blk_ok && pg_ok && !used_rows[op.block][op.page]) begin
               used_rows[op.block][op.page] = 1'b1;
               used_pages = sat_inc(used_pages);
            end
         end
         gcvs_pkg::FUNC_MARK_DIRTY: begin
            if (blk_ok && pg_ok && !dirty_rows[op.block][op.page]) begin
               dirty_rows[op.block][op.page] = 1'b1;
               dirty_pages = sat_inc(dirty_pages);
            end
         end
         gcvs_pkg::FUNC_ERASE: begin
            if (blk_ok) begin
               used_pages  = sat_dec(used_pages, ones_in(used_rows[op.block] & ROW_MASK));
               dirty_pages = sat_dec(dirty_pages, ones_in(dirty_rows[op.block] & ROW_MASK));
               used_rows[op.block]  = '0;
               dirty_rows[op.block] = '0;
            end
         end
         gcvs_pkg::FUNC_PICK, gcvs_pkg::FUNC_PICK_PLANE: begin
            if (op.func == gcvs_pkg::FUNC_PICK) begin
               lo = scan_ptr;
               hi = NUM_BLOCKS;
            end else begin
               lo = op.plane * BLOCKS_IN_PLANE;
               hi = lo + BLOCKS_IN_PLANE;
               if (hi > NUM_BLOCKS) begin
                  hi = NUM_BLOCKS;
               end
            end
            best   = 0;
            best_n = 0;
            for (int unsigned b = lo; b < hi; b++) begin
               n = ones_in(dirty_rows[b] & ROW_MASK);
               if (n > best_n) begin
                  best_n = n;
                  best   = b;
               end
            end
            if (op.func == gcvs_pkg::FUNC_PICK) begin
               scan_ptr = (best + 1) % NUM_BLOCKS;
            end
            res.victim_block       = gcvs_pkg::BLOCK_W'(best);
            res.victim_dirty_pages = gcvs_pkg::PCNT_W'(ones_in(dirty_rows[best] & ROW_MASK));
            res.live_pages         = gcvs_pkg::PCNT_W'(
               ones_in(used_rows[best] & ~dirty_rows[best] & ROW_MASK));
         end
         default: begin
         end
      endcase
      res.used_total      = used_pages;
      res.dirty_total     = dirty_pages;
      res.idle_gc_wanted  = used_pages > idle_thr;
      res.panic_gc_wanted = used_pages >= force_thr;
      res.full_no_dirty   = (used_pages >= NUM_BLOCKS * PAGES_IN_BLOCK) && (dirty_pages == 0);
      return res;
   endfunction

   function automatic string describe(input gcvs_pkg::rsp_type r);
      return $sformatf("blk %0d dirty %0d live %0d used %0d dty %0d idle %b panic %b full %b",
                       r.victim_block, r.victim_dirty_pages, r.live_pages, r.used_total,
                       r.dirty_total, r.idle_gc_wanted, r.panic_gc_wanted, r.full_no_dirty);
   endfunction

   always @(posedge clock) begin
      gcvs_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            used_rows[i]  = '0;
            dirty_rows[i] = '0;
         end
         used_pages  = '0;
         dirty_pages = '0;
         scan_ptr    = 0;
         idle_thr    = gcvs_pkg::IDLE_THR_RESET;
         force_thr   = gcvs_pkg::FORCE_THR_RESET;
         owed_head   = 0;
         owed_tail   = 0;
         owed_level  = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == gcvs_pkg::CSR_IDLE_THR) begin
               idle_thr = csr_wdata;
            end else begin
               force_thr = csr_wdata;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_level == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected result transfer: %s", describe(rsp_data));
               end
            end else begin
               want       = owed_results[owed_head];
               owed_head  = (owed_head + 1) % OWED_DEPTH;
               owed_level = owed_level - 1;
               if (rsp_data !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("result mismatch at %0t", $realtime);
                     $display("  expected %s", describe(want));
                     $display("  actual   %s", describe(rsp_data));
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (owed_level == OWED_DEPTH) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("too many transfers in flight at %0t", $realtime);
               end
            end else begin
               owed_results[owed_tail] = predict_gc_op(req_data);
               owed_tail  = (owed_tail + 1) % OWED_DEPTH;
               owed_level = owed_level + 1;
            end
         end
      end
      results_owed = owed_level;
   end

endmodule

[verif/greedy_gc_victim_select_tb.sv]
`timescale 1ns / 100ps

module greedy_gc_victim_select_tb;

   localparam int REQ_W = $bits(gcvs_pkg::req_type);

   logic                         clock     = 1'b0;
   logic                         reset     = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   gcvs_pkg::req_type            req_data  = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b1;
   gcvs_pkg::rsp_type            rsp_data;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic                         csr_index = gcvs_pkg::CSR_IDLE_THR;
   logic [gcvs_pkg::COUNT_W-1:0] csr_wdata = '0;

   int unsigned mismatch_count;
   int unsigned results_owed;
   bit          quiet    = 1'b0;
   int unsigned rsp_hold = 0;
   int unsigned hot_blk [8];

   always #5 clock = ~clock;

   greedy_gc_victim_select DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   greedy_gc_victim_select_checker victim_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial begin
      #30ms;
      $display("greedy_gc_victim_select regression: fail");
      $finish;
   end

   // result side: random stall before each transfer, or one long hold when asked
   initial begin : rsp_side
      int unsigned gap;
      forever begin
         if (rsp_hold != 0) begin
            gap      = rsp_hold;
            rsp_hold = 0;
         end else begin
            gap = quiet ? 0 : $urandom_range(0, 12);
         end
         @(negedge clock);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic gcvs_pkg::req_type make_op(input logic [gcvs_pkg::FUNC_W-1:0] func,
                                                 input int unsigned blk,
                                                 input int unsigned pg,
                                                 input int unsigned pl);
      gcvs_pkg::req_type op;
      op.func  = func;
      op.block = gcvs_pkg::BLOCK_W'(blk);
      op.page  = gcvs_pkg::PAGE_W'(pg);
      op.plane = gcvs_pkg::PLANE_W'(pl);
      return op;
   endfunction

   task automatic push_op(input gcvs_pkg::req_type op);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= op;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (results_owed != 0);
   endtask

   task automatic program_thresholds(input int unsigned idle_level,
                                     input int unsigned panic_level);
      csr_valid <= 1'b1;
      csr_index <= gcvs_pkg::CSR_IDLE_THR;
      csr_wdata <= gcvs_pkg::COUNT_W'(idle_level);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_index <= gcvs_pkg::CSR_FORCE_THR;
      csr_wdata <= gcvs_pkg::COUNT_W'(panic_level);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned       sel, blk, pg;
      gcvs_pkg::req_type op;
      logic [REQ_W-1:0]  raw;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // empty array under reset thresholds
      push_op(make_op(gcvs_pkg::FUNC_PICK, 0, 0, 0));
      push_op(make_op(gcvs_pkg::FUNC_PICK_PLANE, 0, 0, 3));
      wait_idle();
      program_thresholds(0, 0);

      push_op(make_op(gcvs_pkg::FUNC_MARK_USED, 0, 0, 0));
      push_op(make_op(gcvs_pkg::FUNC_MARK_USED, 0, 0, 0));
      push_op(make_op(gcvs_pkg::FUNC_MARK_USED, 1023, 63, 3));
      push_op(make_op(gcvs_pkg::FUNC_MARK_DIRTY, 1023, 63, 0));
      push_op(make_op(gcvs_pkg::FUNC_MARK_DIRTY, 1023, 63, 0));
      push_op(make_op(gcvs_pkg::FUNC_MARK_DIRTY, 512, 5, 0));
      push_op(make_op(gcvs_pkg::FUNC_MARK_DIRTY, 512, 6, 0));
      push_op(make_op(gcvs_pkg::FUNC_MARK_USED, 512, 7, 0));
      // scan pointer walks forward and wraps
      push_op(make_op(gcvs_pkg::FUNC_PICK, 0, 0, 0));
      push_op(make_op(gcvs_pkg::FUNC_PICK, 0, 0, 0));
      push_op(make_op(gcvs_pkg::FUNC_PICK, 0, 0, 0));
      push_op(make_op(gcvs_pkg::FUNC_PICK_PLANE, 0, 0, 2));
      push_op(make_op(gcvs_pkg::FUNC_PICK_PLANE, 0, 0, 1));
      // tie goes to the lower block
      push_op(make_op(gcvs_pkg::FUNC_MARK_DIRTY, 100, 0, 0));
      push_op(make_op(gcvs_pkg::FUNC_MARK_DIRTY, 200, 0, 0));
      push_op(make_op(gcvs_pkg::FUNC_PICK_PLANE, 0, 0, 0));
      push_op(make_op(gcvs_pkg::FUNC_ERASE, 512, 0, 0));
      push_op(make_op(gcvs_pkg::FUNC_ERASE, 512, 63, 3));
      push_op(make_op(gcvs_pkg::FUNC_ERASE, 1023, 0, 0));
      for (int f = gcvs_pkg::FUNC_PICK_PLANE + 1; f < (1 << gcvs_pkg::FUNC_W); f++) begin
         push_op(make_op(gcvs_pkg::FUNC_W'(f), 1023, 63, 3));
      end
      wait_idle();

      for (int ph = 0; ph < 6; ph++) begin
         for (int i = 0; i < 8; i++) begin
            hot_blk[i] = $urandom_range(0, 1023);
         end
         if (ph == 0) begin
            hot_blk[0] = 0;
            hot_blk[7] = 1023;
         end
         quiet = (ph == 3);
         unique case (ph)
            0: program_thresholds(65536, 65536);
            1: program_thresholds(131071, 0);
            default: program_thresholds($urandom_range(0, 160), $urandom_range(0, 160));
         endcase
         if (ph == 2) begin
            rsp_hold = 400;
         end
         for (int i = 0; i < 93; i++) begin
            sel = $urandom_range(0, 99);
            blk = ($urandom_range(0, 9) < 8) ? hot_blk[$urandom_range(0, 7)] :
                                               $urandom_range(0, 1023);
            pg  = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 63);
            op  = make_op(gcvs_pkg::FUNC_MARK_USED, blk, pg, $urandom_range(0, 3));
            if (sel < 34) begin
            end else if (sel < 64) begin
               op.func = gcvs_pkg::FUNC_MARK_DIRTY;
            end else if (sel < 72) begin
               op.func = gcvs_pkg::FUNC_ERASE;
            end else if (sel < 81) begin
               op.func = gcvs_pkg::FUNC_PICK;
            end else if (sel < 93) begin
               op.func = gcvs_pkg::FUNC_PICK_PLANE;
            end else if (sel < 96) begin
               op.func = gcvs_pkg::FUNC_W'($urandom_range(gcvs_pkg::FUNC_PICK_PLANE + 1,
                                                          (1 << gcvs_pkg::FUNC_W) - 1));
            end else begin
               raw = REQ_W'($urandom);
               op  = raw;
            end
            push_op(op);
         end
         wait_idle();
      end

      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("greedy_gc_victim_select regression: pass");
      end else begin
         $display("greedy_gc_victim_select regression: fail");
      end
      $finish;
   end

endmodule

[greedy_gc_victim_select.f]
sv/gcvs_pkg.sv
sv/gcvs_map_ram.sv
sv/greedy_gc_victim_select.sv
verif/greedy_gc_victim_select_checker.sv
verif/greedy_gc_victim_select_tb.sv
